// ----- design/tlsr_pkg.sv -----
// Package for the thick line span rasteriser: opcodes, field widths and the
// command and status structs shared by the controller and the datapath.
// No dependencies.
package tlsr_pkg;

  localparam int PEN_WIDTH_BITS = 8;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic load;  // latch a new line
    logic emit;  // register a span and, unless at the end point, take one step
  } tlsr_cmd_t;

  typedef struct packed {
    logic at_end;  // walk point equals the end point
  } tlsr_sts_t;

endpackage

// ----- design/tlsr_if.sv -----
// Handshake channels of the rasteriser: line command in, span out.
// Depends on tlsr_pkg.
interface tlsr_cmd_if import tlsr_pkg::*; #(parameter int COORD_BITS = 12);
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic signed [COORD_BITS-1:0]     start_x;
  logic signed [COORD_BITS-1:0]     start_y;
  logic signed [COORD_BITS-1:0]     end_x;
  logic signed [COORD_BITS-1:0]     end_y;
  logic                             pen_color;
  logic        [PEN_WIDTH_BITS-1:0] pen_width;

  modport source (output valid, op, start_x, start_y, end_x, end_y, pen_color, pen_width,
                  input ready);
  modport sink   (input valid, op, start_x, start_y, end_x, end_y, pen_color, pen_width,
                  output ready);
endinterface

interface tlsr_span_if import tlsr_pkg::*; #(parameter int COORD_BITS = 12);
  logic                             valid;
  logic                             ready;
  logic signed [COORD_BITS:0]       span_x;
  logic signed [COORD_BITS:0]       span_y;
  logic                             span_horizontal;
  logic        [PEN_WIDTH_BITS-1:0] span_length;
  logic                             span_color;
  logic                             last_span;

  modport source (output valid, span_x, span_y, span_horizontal, span_length, span_color,
                  last_span, input ready);
  modport sink   (input valid, span_x, span_y, span_horizontal, span_length, span_color,
                  last_span, output ready);
endinterface

// ----- design/tlsr_ctrl.sv -----
// Controller of the rasteriser: line active state, handshakes, output valid.
// Depends on tlsr_pkg.
module tlsr_ctrl import tlsr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_op,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  tlsr_sts_t sts,
  output tlsr_cmd_t cmd
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_ACTIVE = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  assign in_ready  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    cmd.load = accept && (in_op == OP_LOAD);
    cmd.emit = accept && (in_op == OP_TICK) && (state_r == ST_ACTIVE);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load) state_nxt = ST_ACTIVE;
      end
      ST_ACTIVE: begin
        if (cmd.emit && sts.at_end) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // a free slot is guaranteed when emitting, since in_ready gated the accept
  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- design/tlsr_dp.sv -----
// Datapath of the rasteriser: line setup, Bresenham step and span register.
// Depends on tlsr_pkg; driven by tlsr_ctrl commands.
module tlsr_dp import tlsr_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                             clk,
  input  tlsr_cmd_t                        cmd,
  output tlsr_sts_t                        sts,
  input  logic signed [COORD_BITS-1:0]     start_x,
  input  logic signed [COORD_BITS-1:0]     start_y,
  input  logic signed [COORD_BITS-1:0]     end_x,
  input  logic signed [COORD_BITS-1:0]     end_y,
  input  logic                             pen_color,
  input  logic        [PEN_WIDTH_BITS-1:0] pen_width,
  output logic signed [COORD_BITS:0]       span_x,
  output logic signed [COORD_BITS:0]       span_y,
  output logic                             span_horizontal,
  output logic        [PEN_WIDTH_BITS-1:0] span_length,
  output logic                             span_color,
  output logic                             last_span
);

  localparam int C = COORD_BITS;

  // line state
  logic signed [C-1:0]             walk_x_r, walk_y_r, target_x_r, target_y_r;
  logic        [C:0]               delta_x_r;
  logic signed [C+1:0]             neg_delta_y_r;
  logic signed [C+2:0]             error_r;
  logic                            step_x_neg_r, step_y_neg_r, steep_r, color_r;
  logic        [PEN_WIDTH_BITS-1:0] width_r;

  // setup
  logic signed [C:0]   diff_x, diff_y;
  logic        [C:0]   abs_x, abs_y;
  logic signed [C+1:0] ndy_ld;
  logic signed [C+2:0] err_ld;

  // step
  logic signed [C+3:0] e2;
  logic                mv_x, mv_y;
  logic signed [C+2:0] err_step;

  // span
  logic [PEN_WIDTH_BITS-2:0] half;
  logic signed [C:0]         wx_ext, wy_ext, half_ext;

  assign diff_x = {end_x[C-1], end_x} - {start_x[C-1], start_x};
  assign diff_y = {end_y[C-1], end_y} - {start_y[C-1], start_y};
  assign abs_x  = diff_x[C] ? -diff_x : diff_x;
  assign abs_y  = diff_y[C] ? -diff_y : diff_y;
  assign ndy_ld = -$signed({1'b0, abs_y});
  assign err_ld = $signed({2'b00, abs_x}) - $signed({2'b00, abs_y});

  // both sides signed, so the compares are two's complement
  assign e2   = {error_r, 1'b0};
  assign mv_x = e2 >= $signed({{2{neg_delta_y_r[C+1]}}, neg_delta_y_r});
  assign mv_y = e2 <= $signed({3'b000, delta_x_r});
  assign err_step = error_r
                  + (mv_x ? {neg_delta_y_r[C+1], neg_delta_y_r} : '0)
                  + (mv_y ? $signed({2'b00, delta_x_r}) : '0);

  assign sts.at_end = (walk_x_r == target_x_r) && (walk_y_r == target_y_r);

  assign half     = width_r[PEN_WIDTH_BITS-1:1];
  assign wx_ext   = {walk_x_r[C-1], walk_x_r};
  assign wy_ext   = {walk_y_r[C-1], walk_y_r};
  assign half_ext = $signed({{(C+2-PEN_WIDTH_BITS){1'b0}}, half});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      walk_x_r      <= start_x;
      walk_y_r      <= start_y;
      target_x_r    <= end_x;
      target_y_r    <= end_y;
      delta_x_r     <= abs_x;
      neg_delta_y_r <= ndy_ld;
      error_r       <= err_ld;
      step_x_neg_r  <= !(start_x < end_x);
      step_y_neg_r  <= !(start_y < end_y);
      steep_r       <= abs_y > abs_x;
      width_r       <= (pen_width == '0) ? PEN_WIDTH_BITS'(1) : pen_width;
      color_r       <= pen_color;
    end else if (cmd.emit && !sts.at_end) begin
      error_r <= err_step;
      if (mv_x) walk_x_r <= step_x_neg_r ? walk_x_r - C'(1) : walk_x_r + C'(1);
      if (mv_y) walk_y_r <= step_y_neg_r ? walk_y_r - C'(1) : walk_y_r + C'(1);
    end
  end

  // span register, written only when a span is emitted
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      span_x          <= steep_r ? wx_ext - half_ext : wx_ext;
      span_y          <= steep_r ? wy_ext : wy_ext - half_ext;
      span_horizontal <= steep_r;
      span_length     <= width_r;
      span_color      <= color_r;
      last_span       <= sts.at_end;
    end
  end

endmodule

// ----- design/thick_line_span_rasterizer.sv -----
// Thick line span rasteriser, top level: tlsr_ctrl and tlsr_dp joined by command/status.
// Latency: a tick's span is in the output register the cycle after it is accepted.
// Throughput: one item per cycle while the sink does not stall; a load or tick each cycle,
// and one Bresenham step per tick until the end point is reached.
// Reset (rst_n, synchronous, active low): line idle, no span pending.
module thick_line_span_rasterizer import tlsr_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  tlsr_cmd_if.sink      in_line,
  tlsr_span_if.source   out_span
);

  tlsr_cmd_t cmd;
  tlsr_sts_t sts;

  // Controller: owns line-active state and the output valid flag.
  // in_ready drops only while a finished span waits and the sink stalls.
  tlsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_line.valid),
    .in_op     (in_line.op),
    .in_ready  (in_line.ready),
    .out_valid (out_span.valid),
    .out_ready (out_span.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: line setup on load; on a tick, registers the span at the
  // current walk point (offset by half the thickness across the major
  // axis) and then, unless at the end point, advances the error term by one step.
  tlsr_dp #(.COORD_BITS(COORD_BITS)) u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .sts             (sts),
    .start_x         (in_line.start_x),
    .start_y         (in_line.start_y),
    .end_x           (in_line.end_x),
    .end_y           (in_line.end_y),
    .pen_color       (in_line.pen_color),
    .pen_width       (in_line.pen_width),
    .span_x          (out_span.span_x),
    .span_y          (out_span.span_y),
    .span_horizontal (out_span.span_horizontal),
    .span_length     (out_span.span_length),
    .span_color      (out_span.span_color),
    .last_span       (out_span.last_span)
  );

  // a load and an emit never share a cycle
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.emit))
    else $error("load and emit together");

  // an emitted span is presented the next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_span.valid)
    else $error("emitted span not presented");

  // after the end-point span the line is idle, so no further emit
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.at_end) |=> !cmd.emit)
    else $error("span emitted after line end");

  // the end-point span carries the last flag
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.at_end) |=> out_span.last_span)
    else $error("last flag missing on end span");

endmodule
